/* sv/reli_pkg.sv */
// ----------------------------------------------------------------------------
// reli_pkg
// Types and constants shared by the range-energy loss interpolator.
// ----------------------------------------------------------------------------
package reli_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_EXIT = 2'd1;
  localparam logic [1:0] CMD_ENTRY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_CUTOFF = 2'd1;
  localparam logic [1:0] ST_STOPPED = 2'd2;
  localparam logic [1:0] ST_SAT = 2'd3;

  localparam logic [1:0] REG_MASS = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_CUTOFF = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PN_DIV,
    S_PN_END,
    S_SRCH_RD,
    S_SRCH_WT,
    S_SRCH_CMP,
    S_SEG_RD0,
    S_SEG_RD1,
    S_SEG_WT,
    S_SEG_LAT,
    S_MUL,
    S_DIV,
    S_INTERP,
    S_TOT_MUL,
    S_TOT_END,
    S_OUT
  } state_t;

  // Request to the shared divider and its answer.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

/* sv/reli_ram.sv */
// ----------------------------------------------------------------------------
// reli_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module reli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/reli_div.sv */
// ----------------------------------------------------------------------------
// reli_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module reli_div (
  input  logic               clk,
  input  logic               rst,
  input  reli_pkg::div_req_t req,
  output reli_pkg::div_rsp_t rsp
);
  import reli_pkg::*;

  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo;

endmodule

/* sv/range_energy_loss_interpolator.sv */
// ----------------------------------------------------------------------------
// range_energy_loss_interpolator
// Range-energy table with exit and entry energy queries for a layer.
// ----------------------------------------------------------------------------
// A load, a zero-thickness query or an unused command goes from idle straight to
// the output state. A query that runs both lookups does a per-nucleon divide,
// then per lookup a binary search (up to 11 probes) and an interpolation divide.
// Stopped or cut-off queries end sooner. One word is worked on at a time. Reset
// clears control state and loads the register defaults; the table is undefined
// until written.
module range_energy_loss_interpolator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata, low bit up: table_index[10:0], point_energy[42:11],
  // point_range[74:43], query_energy[106:75], query_thickness[138:107], pad
  input  logic [143:0] s_tdata,
  // tuser: command[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata, low bit up: result_energy[31:0]
  output logic [31:0]  m_tdata,
  // tuser: status[1:0]
  output logic [1:0]   m_tuser
);
  import reli_pkg::*;

  // Configuration registers.
  logic [15:0] ion_mass;
  logic [11:0] point_count;
  logic [15:0] cutoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      ion_mass    <= 16'd256;
      point_count <= 12'd2;
      cutoff      <= 16'd3277;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASS:   ion_mass <= cfg_data;
        REG_COUNT:  point_count <= cfg_data[11:0];
        REG_CUTOFF: cutoff <= cfg_data;
        default: ;
      endcase
    end
  end

  // Points in use, clamped to [2, TABLE_DEPTH]; two less is the hi bound of the search.
  logic [CNT_W-1:0] used_n;
  always_comb begin
    if (point_count < 12'd2) used_n = CNT_W'(2);
    else if (32'(point_count) > TABLE_DEPTH) used_n = CNT_W'(TABLE_DEPTH);
    else used_n = CNT_W'(point_count);
  end

  state_t state, state_next;

  // Held query fields.
  logic [1:0]  cmd;
  logic [31:0] qe, qt;
  // Working values.
  logic [31:0] xq;                 // lookup key
  logic        dir;                // 0: energy to range, 1: range to energy
  logic        pass;               // 0 first lookup, 1 second lookup
  logic        sat;
  logic [ADDR_W-1:0] lo, hi, mid;
  logic [31:0] x0, y0, x1, y1, rd_x, rd_y;
  logic [63:0] prod;
  logic        neg;
  logic [31:0] adx;
  logic [31:0] res;
  logic [1:0]  st;
  logic        div_go;             // first cycle of the interpolation divide

  // Table memories.
  logic              tab_we;
  logic [ADDR_W-1:0] tab_addr;
  logic [31:0]       e_rd, r_rd;
  logic              acc;

  assign acc = s_tvalid && s_tready;
  assign tab_we = acc && s_tuser == CMD_LOAD && 32'(s_tdata[10:0]) < TABLE_DEPTH;

  always_comb begin
    if (state == S_IDLE) tab_addr = s_tdata[ADDR_W-1:0];
    else if (state == S_SEG_RD1) tab_addr = lo + ADDR_W'(1);
    else if (state == S_SEG_RD0) tab_addr = lo;
    else tab_addr = mid;
  end

  reli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_energy (
    .clk(clk), .we(tab_we), .addr(tab_addr), .wdata(s_tdata[42:11]), .rdata(e_rd)
  );
  reli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_range (
    .clk(clk), .we(tab_we), .addr(tab_addr), .wdata(s_tdata[74:43]), .rdata(r_rd)
  );

  assign rd_x = dir ? r_rd : e_rd;
  assign rd_y = dir ? e_rd : r_rd;

  // Shared divider.
  div_req_t dreq;
  div_rsp_t drsp;
  reli_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = prod;
    dreq.divisor = adx;
    if (state == S_IDLE && acc && (s_tuser == CMD_EXIT || s_tuser == CMD_ENTRY)
        && s_tdata[138:107] != 32'd0 && ion_mass != 16'd0) begin
      dreq.start = 1'b1;
      dreq.dividend = {24'd0, s_tdata[106:75], 8'd0};
      dreq.divisor = {16'd0, ion_mass};
    end else if (state == S_DIV && div_go && adx != 32'd0) begin
      dreq.start = 1'b1;
    end
  end

  // Interpolated value, clamped.
  logic [63:0] q;
  logic [32:0] isum;
  logic [31:0] ival;
  logic        isat;
  assign q = drsp.quotient;
  always_comb begin
    isat = 1'b0;
    isum = '0;
    if (adx == 32'd0) begin
      ival = y0;
    end else if (!neg) begin
      isum = {1'b0, y0} + {1'b0, q[31:0]};
      if (q[63:32] != 32'd0 || isum[32]) begin
        ival = 32'hFFFF_FFFF;
        isat = 1'b1;
      end else begin
        ival = isum[31:0];
      end
    end else if (q >= {32'd0, y0}) begin
      ival = 32'd0;
    end else begin
      ival = y0 - q[31:0];
    end
  end

  // Per-nucleon energy, saturated for a zero mass or a quotient too wide.
  logic        pn_sat;
  logic [31:0] pn_val;
  assign pn_sat = (ion_mass == 16'd0) || (q[63:32] != 32'd0);
  assign pn_val = pn_sat ? 32'hFFFF_FFFF : q[31:0];

  logic [32:0] rsum;
  assign rsum = {1'b0, ival} + {1'b0, qt};
  logic [31:0] dx_s, dy_s;
  logic [32:0] num_s;

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if ((s_tuser == CMD_EXIT || s_tuser == CMD_ENTRY) && s_tdata[138:107] != 32'd0) begin
            state_next = S_PN_DIV;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_PN_DIV:   if (!dreq.start && !drsp.busy) state_next = S_PN_END;
      S_PN_END: begin
        // An exit query below the cutoff is done; an entry query starts from
        // zero range instead.
        if (pn_val <= {16'd0, cutoff} && cmd == CMD_EXIT) state_next = S_OUT;
        else state_next = S_SRCH_RD;
      end
      S_SRCH_RD:  state_next = (lo < hi) ? S_SRCH_WT : S_SEG_RD0;
      S_SRCH_WT:  state_next = S_SRCH_CMP;
      S_SRCH_CMP: state_next = S_SRCH_RD;
      S_SEG_RD0:  state_next = S_SEG_RD1;
      S_SEG_RD1:  state_next = S_SEG_WT;
      S_SEG_WT:   state_next = S_SEG_LAT;
      S_SEG_LAT:  state_next = S_MUL;
      S_MUL:      state_next = S_DIV;
      S_DIV:      if (!div_go && !drsp.busy) state_next = S_INTERP;
      S_INTERP: begin
        if (!pass && cmd == CMD_EXIT) begin
          state_next = (ival <= qt) ? S_OUT : S_SRCH_RD;
        end else if (!pass) begin
          state_next = S_SRCH_RD;
        end else if (cmd == CMD_EXIT && ival <= {16'd0, cutoff}) begin
          state_next = S_OUT;
        end else begin
          state_next = S_TOT_MUL;
        end
      end
      S_TOT_MUL:  state_next = S_TOT_END;
      S_TOT_END:  state_next = S_OUT;
      S_OUT:      state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Signed differences for the segment (kept as magnitudes and a sign).
  assign dx_s = (x1 >= x0) ? x1 - x0 : x0 - x1;
  assign dy_s = (y1 >= y0) ? y1 - y0 : y0 - y1;
  assign num_s = {1'b0, xq} - {1'b0, x0};

  logic [31:0] an;
  assign an = num_s[32] ? x0 - xq : xq - x0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      div_go <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      state <= state_next;
      div_go <= (state == S_MUL);
      case (state)
        S_IDLE: begin
          if (acc) begin
            cmd <= s_tuser;
            qe <= s_tdata[106:75];
            qt <= s_tdata[138:107];
            sat <= 1'b0;
            st <= ST_OK;
            dir <= 1'b0;
            pass <= 1'b0;
            if ((s_tuser == CMD_EXIT || s_tuser == CMD_ENTRY)
                && s_tdata[138:107] == 32'd0) begin
              res <= s_tdata[106:75];
            end else begin
              res <= 32'd0;
            end
          end
        end
        S_PN_END: begin
          // Per-nucleon energy and the cutoff checks that follow it.
          lo <= '0;
          hi <= ADDR_W'(used_n - CNT_W'(2));
          if (pn_sat) sat <= 1'b1;
          if (pn_val <= {16'd0, cutoff}) begin
            if (cmd == CMD_EXIT) begin
              st <= ST_CUTOFF;
            end else begin
              // Entry starts from zero range.
              xq <= qt;
              dir <= 1'b1;
              pass <= 1'b1;
            end
          end else begin
            xq <= pn_val;
          end
        end
        S_SRCH_RD: mid <= ADDR_W'(({1'b0, lo} + {1'b0, hi} + 1'b1) >> 1);
        S_SRCH_CMP: begin
          if (rd_x <= xq) lo <= mid;
          else hi <= mid - ADDR_W'(1);
        end
        // The RAM read is registered, so the lower point
        // arrives during S_SEG_RD1 and the upper one during S_SEG_WT.
        S_SEG_RD1: begin
          x0 <= rd_x;
          y0 <= rd_y;
        end
        S_SEG_WT: begin
          x1 <= rd_x;
          y1 <= rd_y;
        end
        S_MUL: begin
          prod <= 64'(an) * 64'(dy_s);
          adx <= dx_s;
          neg <= (num_s[32] != (y1 < y0)) != (x1 < x0);
        end
        S_INTERP: begin
          if (isat) sat <= 1'b1;
          lo <= '0;
          hi <= ADDR_W'(used_n - CNT_W'(2));
          if (!pass && cmd == CMD_EXIT) begin
            if (ival <= qt) begin
              st <= ST_STOPPED;
            end else begin
              xq <= ival - qt;
              dir <= 1'b1;
              pass <= 1'b1;
            end
          end else if (!pass) begin
            if (rsum[32]) begin
              xq <= 32'hFFFF_FFFF;
              sat <= 1'b1;
            end else begin
              xq <= rsum[31:0];
            end
            dir <= 1'b1;
            pass <= 1'b1;
          end else if (cmd == CMD_EXIT && ival <= {16'd0, cutoff}) begin
            st <= ST_CUTOFF;
          end else begin
            xq <= ival;
          end
        end
        S_TOT_MUL: prod <= 64'(xq) * 64'(ion_mass);
        S_TOT_END: begin
          if (prod[63:40] != 24'd0) begin
            res <= 32'hFFFF_FFFF;
            st <= ST_SAT;
          end else begin
            res <= prod[39:8];
            st <= sat ? ST_SAT : ST_OK;
          end
        end
        S_OUT: m_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_tdata = res;
  assign m_tuser = st;

  // The table only changes on a load accepted while idle.
  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    tab_we |-> state == S_IDLE) else $error("table write outside idle");
  // No new word while a result waits.
  a_no_acc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("ready while result pending");
  // Result appears only from the output state.
  a_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT) else $error("stray result");
  // Divider is started only when idle.
  a_div: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !drsp.busy) else $error("divider restarted while busy");

endmodule

/* test/range_energy_loss_interpolator_tb.sv */
// ----------------------------------------------------------------------------
// range_energy_loss_interpolator_tb
// Loads range-energy tables of several sizes, up to 800 points, and sends
// exit and entry energy queries under a series of mass, point count and cutoff
// settings. Each query is predicted here in fixed point and checked against
// the result word. Both stream sides idle at random, and the result side is
// held off for one long stretch.
// ----------------------------------------------------------------------------
module range_energy_loss_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import reli_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [10:0] idx;
    logic [31:0] pe;
    logic [31:0] pr;
    logic [31:0] qe;
    logic [31:0] qt;
  } word_t;

  typedef struct {
    logic [31:0] energy;
    logic [1:0]  status;
  } outcome_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = REG_MASS;
  logic [15:0]  cfg_data = '0;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;
  logic [1:0]   m_tuser;

  range_energy_loss_interpolator uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be sent, and the outcomes the block still owes us.
  word_t    send_q[$];
  outcome_t outcome_q[$];
  word_t    cur_word;
  int       errors = 0;
  int       cycle = 0;
  logic     hold_off = 1'b0;

  // Predictor state: its own copy of the table and the registers.
  logic [31:0] tab_e[TABLE_DEPTH];
  logic [31:0] tab_r[TABLE_DEPTH];
  logic [15:0] mass_q = 16'd256;
  logic [11:0] count_q = 12'd2;
  logic [15:0] cutoff_q = 16'd3277;
  bit          sat_seen;

  // Copy of the table as the stimulus builds it, used to aim queries.
  logic [31:0] gen_e[TABLE_DEPTH];
  logic [31:0] gen_r[TABLE_DEPTH];

  always @(posedge clk) cycle <= cycle + 1;

  // The quiet window gives a long stretch with no idling on either side.
  function automatic bit idle_now();
    if (cycle >= 20000 && cycle < 60000) return 1'b0;
    return $urandom_range(0, 99) < 19;
  endfunction

  function automatic int unsigned points_used();
    if (count_q < 2) return 2;
    if (count_q > TABLE_DEPTH) return TABLE_DEPTH;
    return count_q;
  endfunction

  // Piecewise linear lookup. With by_range set, x is the range axis and y the
  // energy axis; otherwise the other way round. The end segments extrapolate.
  function automatic logic [31:0] interpolate(bit by_range, logic [31:0] xq);
    int unsigned lo, hi, mid;
    longint      x0, x1, y0, y1, dx, num, dy;
    logic [63:0] an, ady, adx, q, base;
    bit          neg;
    lo = 0;
    hi = points_used() - 2;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if ((by_range ? tab_r[mid] : tab_e[mid]) <= xq) lo = mid;
      else hi = mid - 1;
    end
    x0 = by_range ? tab_r[lo] : tab_e[lo];
    x1 = by_range ? tab_r[lo + 1] : tab_e[lo + 1];
    y0 = by_range ? tab_e[lo] : tab_r[lo];
    y1 = by_range ? tab_e[lo + 1] : tab_r[lo + 1];
    dx = x1 - x0;
    if (dx == 0) return y0[31:0];
    num = longint'(xq) - x0;
    dy = y1 - y0;
    an = num < 0 ? -num : num;
    ady = dy < 0 ? -dy : dy;
    adx = dx < 0 ? -dx : dx;
    neg = ((num < 0) != (dy < 0)) != (dx < 0);
    q = (an * ady) / adx;
    base = y0;
    if (!neg) begin
      if (q > 64'hFFFF_FFFF - base) begin
        sat_seen = 1'b1;
        return 32'hFFFF_FFFF;
      end
      return base[31:0] + q[31:0];
    end
    if (q >= base) return 32'd0;
    return base[31:0] - q[31:0];
  endfunction

  function automatic logic [31:0] per_nucleon(logic [31:0] e);
    logic [63:0] v;
    if (mass_q == 0) begin
      sat_seen = 1'b1;
      return 32'hFFFF_FFFF;
    end
    v = {24'd0, e, 8'd0} / mass_q;
    if (v > 64'hFFFF_FFFF) begin
      sat_seen = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] total_energy(logic [31:0] eu);
    logic [63:0] v;
    v = (64'(eu) * mass_q) >> 8;
    if (v > 64'hFFFF_FFFF) begin
      sat_seen = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

  // Works out the result word for one accepted input word.
  function automatic outcome_t layer_energy(word_t w);
    outcome_t    o;
    logic [31:0] eu, rng, eo;
    logic [32:0] sum;
    o.energy = '0;
    o.status = ST_OK;
    sat_seen = 1'b0;
    if (w.cmd == CMD_LOAD) begin
      tab_e[w.idx] = w.pe;
      tab_r[w.idx] = w.pr;
    end else if (w.cmd == CMD_EXIT || w.cmd == CMD_ENTRY) begin
      if (w.qt == 0) begin
        o.energy = w.qe;
      end else if (w.cmd == CMD_EXIT) begin
        eu = per_nucleon(w.qe);
        if (eu <= cutoff_q) begin
          o.status = ST_CUTOFF;
        end else begin
          rng = interpolate(1'b0, eu);
          if (rng <= w.qt) begin
            o.status = ST_STOPPED;
          end else begin
            eo = interpolate(1'b1, rng - w.qt);
            if (eo <= cutoff_q) begin
              o.status = ST_CUTOFF;
            end else begin
              o.energy = total_energy(eo);
              o.status = sat_seen ? ST_SAT : ST_OK;
            end
          end
        end
      end else begin
        // Below the cutoff the ion is taken to start with no range at all.
        eu = per_nucleon(w.qe);
        rng = 32'd0;
        if (eu > cutoff_q) rng = interpolate(1'b0, eu);
        sum = 33'(rng) + w.qt;
        if (sum[32]) begin
          sat_seen = 1'b1;
          sum = 33'h0_FFFF_FFFF;
        end
        eo = interpolate(1'b1, sum[31:0]);
        o.energy = total_energy(eo);
        o.status = sat_seen ? ST_SAT : ST_OK;
      end
    end
    return o;
  endfunction

  // Input side: one word is offered at a time from send_q.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= CMD_LOAD;
    end else begin
      if (s_tvalid && s_tready) outcome_q.push_back(layer_energy(cur_word));
      if (!s_tvalid || s_tready) begin
        if (send_q.size() > 0 && !idle_now()) begin
          cur_word = send_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {5'd0, cur_word.qt, cur_word.qe, cur_word.pr, cur_word.pe,
                      cur_word.idx};
          s_tuser <= cur_word.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle, what, got, want);
    errors++;
  endtask

  // Result side: checks each word against the oldest outcome owed.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected word, energy", m_tdata, 32'd0);
        end else begin
          want = outcome_q.pop_front();
          if (m_tdata !== want.energy) report_mismatch("result_energy", m_tdata, want.energy);
          if (m_tuser !== want.status) begin
            report_mismatch("status", 32'(m_tuser), 32'(want.status));
          end
        end
      end
      m_tready <= !hold_off && !idle_now();
    end
  end

  // The long hold-off, so that the block backs up and stalls its input.
  initial begin
    wait (!rst);
    repeat (3000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (2500) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #50ms;
    $display("range_energy_loss_interpolator verification failed");
    $finish;
  end

  task automatic push_word(input logic [1:0] cmd, input logic [10:0] idx,
                           input logic [31:0] pe, input logic [31:0] pr,
                           input logic [31:0] qe, input logic [31:0] qt);
    word_t w;
    w.cmd = cmd;
    w.idx = idx;
    w.pe = pe;
    w.pr = pr;
    w.qe = qe;
    w.qt = qt;
    send_q.push_back(w);
  endtask

  // Builds an ascending table of n points with random steps and the odd flat
  // segment, and queues the loads for it.
  task automatic load_table(input int unsigned n);
    logic [32:0] e, r;
    int unsigned estep, rstep;
    estep = $urandom_range(4, 20);
    rstep = $urandom_range(2, 20);
    e = $urandom_range(0, 4000);
    r = $urandom_range(0, 300);
    for (int unsigned i = 0; i < n; i++) begin
      gen_e[i] = e[31:0];
      gen_r[i] = r[31:0];
      push_word(CMD_LOAD, i[10:0], e[31:0], r[31:0], $urandom, $urandom);
      if ($urandom_range(0, 19) != 0) e = e + $urandom_range(1, 1 << estep);
      if ($urandom_range(0, 19) != 0) r = r + $urandom_range(1, 1 << rstep);
      if (e[32]) e = 33'h0_FFFF_FFFF;
      if (r[32]) r = 33'h0_FFFF_FFFF;
    end
  endtask

  // One random word aimed at a table of n points: mostly queries that land in
  // or near the table, some noise loads and unused commands.
  task automatic random_word(input int unsigned n);
    int unsigned pick;
    logic [31:0] eu, qe, qt;
    logic [63:0] scaled;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      push_word(CMD_LOAD, 11'($urandom_range(0, n - 1)), $urandom, $urandom,
                $urandom, $urandom);
      return;
    end
    if (pick < 8) begin
      push_word(2'd3, 11'($urandom), $urandom, $urandom, $urandom, $urandom);
      return;
    end
    eu = gen_e[$urandom_range(0, n - 1)] + ($urandom & ((32'd1 << $urandom_range(0, 22)) - 1));
    scaled = (64'(eu) * mass_q) >> 8;
    case ($urandom_range(0, 9))
      0: qe = $urandom;
      1: qe = $urandom_range(0, 70000);
      default: qe = scaled > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : scaled[31:0];
    endcase
    case ($urandom_range(0, 9))
      0: qt = 32'd0;
      1: qt = $urandom;
      2: qt = $urandom_range(1, 255);
      default: qt = (gen_r[$urandom_range(0, n - 1)] >> $urandom_range(0, 6)) + 1;
    endcase
    push_word(pick < 54 ? CMD_EXIT : CMD_ENTRY, 11'($urandom), $urandom, $urandom,
              qe, qt);
  endtask

  task automatic drain();
    wait (send_q.size() == 0 && !s_tvalid && outcome_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      REG_MASS:   mass_q = value;
      REG_COUNT:  count_q = value[11:0];
      REG_CUTOFF: cutoff_q = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One phase: set the registers, load a fresh table, then send queries.
  task automatic run_phase(input logic [15:0] mass, input logic [15:0] count,
                           input logic [15:0] cutoff, input int unsigned queries);
    int unsigned n;
    drain();
    write_reg(REG_MASS, mass);
    write_reg(REG_COUNT, count);
    write_reg(REG_CUTOFF, cutoff);
    n = points_used();
    load_table(n);
    for (int unsigned i = 0; i < queries; i++) random_word(n);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings, on a two-point table.
    load_table(2);
    push_word(CMD_EXIT, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    push_word(CMD_ENTRY, 11'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_word(2'd3, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    push_word(CMD_EXIT, 11'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    push_word(CMD_EXIT, 11'd0, 32'd0, 32'd0, 32'd3277, 32'd5);
    push_word(CMD_EXIT, 11'd0, 32'd0, 32'd0, 32'd3278, 32'd5);
    push_word(CMD_EXIT, 11'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
    push_word(CMD_EXIT, 11'd0, 32'd0, 32'd0, gen_e[1], 32'hFFFF_FFFF);
    push_word(CMD_EXIT, 11'd0, 32'd0, 32'd0, gen_e[1], gen_r[1] - gen_r[0]);
    push_word(CMD_EXIT, 11'd0, 32'd0, 32'd0, gen_e[1], 32'd1);
    push_word(CMD_ENTRY, 11'd0, 32'd0, 32'd0, 32'd0, 32'd100);
    push_word(CMD_ENTRY, 11'd0, 32'd0, 32'd0, gen_e[0], 32'd1);
    push_word(CMD_ENTRY, 11'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_word(CMD_ENTRY, 11'd0, 32'd0, 32'd0, gen_e[1], 32'h8000_0000);
    push_word(CMD_LOAD, 11'd1, gen_e[0], gen_r[0], 32'd0, 32'd0);
    push_word(CMD_EXIT, 11'd0, 32'd0, 32'd0, gen_e[0] + 32'd500, 32'd1);
    push_word(CMD_ENTRY, 11'd0, 32'd0, 32'd0, gen_e[0] + 32'd500, 32'd1);
    for (int i = 0; i < 100; i++) random_word(2);

    // Extremes of the registers, a zero mass and a large table.
    run_phase(16'd256, 16'd16, 16'd3277, 70);
    run_phase(16'hFFFF, 16'd0, 16'd0, 70);
    run_phase(16'd1, 16'd3, 16'hFFFF, 60);
    run_phase(16'd0, 16'd12, 16'd500, 40);
    run_phase(16'd4000, 16'd800, 16'd100, 40);
    run_phase(16'd256, 16'd1, 16'd3277, 50);
    for (int p = 0; p < 4; p++) begin
      run_phase(16'($urandom_range(1, 16000)), 16'($urandom_range(2, 48)),
                $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000)),
                70);
    end

    drain();
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("range_energy_loss_interpolator verification clean");
    end else begin
      $display("range_energy_loss_interpolator verification failed");
    end
    $finish;
  end

endmodule
